>>> rtl/cmas_pkg.sv
`timescale 1ns / 1ps

package cmas_pkg;

  localparam int LINE_OUT_W = 20;
  localparam int MARKER_SLOTS = 32;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_EOF  = 2'd2;

  // Marker keyword, first byte at index 0; unused slots are zero.
  localparam logic [7:0] MARKER [MARKER_SLOTS] = '{
    8'h45, 8'h54, 8'h45, 8'h53, 8'h54, 8'h5F, 8'h44, 8'h45,
    8'h46, 8'h49, 8'h4E, 8'h45, 8'h5F, 8'h54, 8'h45, 8'h53,
    8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
    logic       is_slash;
    logic       is_star;
    logic       is_nl;
    logic       is_tab;
    logic       is_space;
    logic       is_lparen;
    logic       is_rparen;
  } item_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [7:0]            ch;
    logic [LINE_OUT_W-1:0] line;
  } res_t;

endpackage

>>> rtl/cmas_fifo.sv
`timescale 1ns / 1ps

module cmas_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

>>> rtl/cmas_front.sv
`timescale 1ns / 1ps

module cmas_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic [7:0]     source_byte,
  input  logic           end_of_file,
  input  logic           item_pop,
  output cmas_pkg::item_t item,
  output logic           item_empty
);

  cmas_pkg::item_t classified;

  always_comb begin
    classified.data      = source_byte;
    classified.eof       = end_of_file;
    classified.is_slash  = (source_byte == cmas_pkg::CH_SLASH);
    classified.is_star   = (source_byte == cmas_pkg::CH_STAR);
    classified.is_nl     = (source_byte == cmas_pkg::CH_NL);
    classified.is_tab    = (source_byte == cmas_pkg::CH_TAB);
    classified.is_space  = (source_byte == cmas_pkg::CH_SPACE);
    classified.is_lparen = (source_byte == cmas_pkg::CH_LPAREN);
    classified.is_rparen = (source_byte == cmas_pkg::CH_RPAREN);
  end

  cmas_fifo #(
    .WIDTH($bits(cmas_pkg::item_t)),
    .DEPTH(2)
  ) u_item_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (push),
    .wr_data(classified),
    .full   (full),
    .rd_en  (item_pop),
    .rd_data(item),
    .empty  (item_empty)
  );

endmodule

>>> rtl/cmas_back.sv
`timescale 1ns / 1ps

module cmas_back #(
  parameter int KEYWORD_LENGTH = 17,
  parameter int LINE_BITS      = 20
) (
  input  logic            clk,
  input  logic            rst,
  input  cmas_pkg::item_t item,
  input  logic            item_empty,
  output logic            item_pop,
  input  logic            pop,
  output cmas_pkg::res_t  res_out,
  output logic            empty
);

  localparam int HIST_DEPTH = (KEYWORD_LENGTH > 1) ? KEYWORD_LENGTH - 1 : 1;
  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;
  localparam logic [4:0] RUN_NEED = 5'(KEYWORD_LENGTH - 1);

  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_LINE,
    MODE_BLOCK
  } mode_t;

  typedef enum logic [1:0] {
    PH_SCAN,
    PH_SEEK,
    PH_SKIP,
    PH_NAME
  } phase_t;

  mode_t                mode, mode_next;
  phase_t               phase, phase_next;
  logic                 slash_p, slash_p_next;
  logic                 star_p, star_p_next;
  logic [7:0]           hist [HIST_DEPTH];
  logic [7:0]           hist_next [HIST_DEPTH];
  logic [7:0]           hist1 [HIST_DEPTH];
  logic [4:0]           run, run_next, run1;
  logic [LINE_BITS-1:0] line_count, line_count_next;
  logic [LINE_BITS-1:0] name_line, name_line_next, name_line_used;
  logic [LINE_BITS+19:0] line_wide;
  logic                 res_valid;
  cmas_pkg::res_t       res;
  logic                 out_full;
  logic                 comment_start;
  logic                 kw_hit;

  assign item_pop       = !item_empty && !out_full;
  assign name_line_used = (phase == PH_SKIP) ? line_count : name_line;
  assign line_wide      = (LINE_BITS + 20)'(name_line_used);

  always_comb begin
    // A held slash that turned out not to open a comment goes into history first.
    for (int i = 0; i < HIST_DEPTH; i++) begin
      if (slash_p && !(item.is_star || item.is_slash)) begin
        hist1[i] = (i == 0) ? cmas_pkg::CH_SLASH : hist[(i == 0) ? 0 : i - 1];
      end else begin
        hist1[i] = hist[i];
      end
    end
    if (slash_p && !(item.is_star || item.is_slash) && run != 5'd31) begin
      run1 = run + 5'd1;
    end else begin
      run1 = run;
    end

    kw_hit = (item.data == cmas_pkg::MARKER[5'(KEYWORD_LENGTH - 1)]) && (run1 >= RUN_NEED);
    for (int i = 0; i < HIST_DEPTH; i++) begin
      if (i < KEYWORD_LENGTH - 1 &&
          hist1[i] != cmas_pkg::MARKER[5'(KEYWORD_LENGTH - 2 - i)]) begin
        kw_hit = 1'b0;
      end
    end
  end

  always_comb begin
    mode_next       = mode;
    phase_next      = phase;
    slash_p_next    = slash_p;
    star_p_next     = star_p;
    run_next        = run;
    name_line_next  = name_line;
    line_count_next = line_count;
    comment_start   = 1'b0;
    res_valid       = 1'b0;
    res.kind        = cmas_pkg::KIND_EOF;
    res.ch          = '0;
    res.line        = '0;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      hist_next[i] = hist[i];
    end

    unique case (phase)
      PH_SCAN: begin
        unique case (mode)
          MODE_BLOCK: begin
            if (star_p && item.is_slash) begin
              star_p_next = 1'b0;
              mode_next   = MODE_PLAIN;
            end else begin
              star_p_next = item.is_star && !item.eof;
            end
          end
          MODE_LINE: begin
            if (item.is_nl) begin
              mode_next = MODE_PLAIN;
            end
          end
          default: begin
            if (slash_p) begin
              slash_p_next = 1'b0;
              if (item.is_star || item.is_slash) begin
                mode_next     = item.is_star ? MODE_BLOCK : MODE_LINE;
                run_next      = '0;
                comment_start = 1'b1;
              end
            end
            if (!comment_start) begin
              for (int i = 0; i < HIST_DEPTH; i++) begin
                hist_next[i] = hist1[i];
              end
              run_next = run1;
              if (item.is_slash && !item.eof) begin
                slash_p_next = 1'b1;
              end else if (kw_hit) begin
                phase_next = PH_SEEK;
                run_next   = '0;
                if (item.eof) begin
                  res_valid = 1'b1;
                end
              end else begin
                for (int i = 0; i < HIST_DEPTH; i++) begin
                  hist_next[i] = (i == 0) ? item.data : hist1[(i == 0) ? 0 : i - 1];
                end
                run_next = (run1 == 5'd31) ? run1 : run1 + 5'd1;
              end
            end
          end
        endcase
      end
      PH_SEEK: begin
        if (item.eof) begin
          res_valid = 1'b1;
        end else if (item.is_lparen) begin
          phase_next = PH_SKIP;
        end
      end
      default: begin
        if (phase == PH_SKIP && item.is_space) begin
          res_valid = item.eof;
        end else begin
          name_line_next = name_line_used;
          phase_next     = PH_NAME;
          if (item.is_rparen) begin
            phase_next = PH_SCAN;
            res_valid  = 1'b1;
            res.kind   = cmas_pkg::KIND_END;
            res.line   = line_wide[cmas_pkg::LINE_OUT_W-1:0];
          end else if (item.eof) begin
            res_valid = 1'b1;
          end else if (!(item.is_nl || item.is_tab)) begin
            res_valid = 1'b1;
            res.kind  = cmas_pkg::KIND_CHAR;
            res.ch    = item.data;
            res.line  = line_wide[cmas_pkg::LINE_OUT_W-1:0];
          end
        end
      end
    endcase

    if (item.is_nl && line_count != LINE_MAX) begin
      line_count_next = line_count + 1'b1;
    end

    // The last byte of a file returns the whole scanner to its reset state.
    if (item.eof) begin
      mode_next       = MODE_PLAIN;
      phase_next      = PH_SCAN;
      slash_p_next    = 1'b0;
      star_p_next     = 1'b0;
      run_next        = '0;
      line_count_next = LINE_BITS'(1);
      name_line_next  = LINE_BITS'(1);
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_next[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_PLAIN;
      phase      <= PH_SCAN;
      slash_p    <= 1'b0;
      star_p     <= 1'b0;
      run        <= '0;
      line_count <= LINE_BITS'(1);
      name_line  <= LINE_BITS'(1);
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist[i] <= '0;
      end
    end else if (item_pop) begin
      mode       <= mode_next;
      phase      <= phase_next;
      slash_p    <= slash_p_next;
      star_p     <= star_p_next;
      run        <= run_next;
      line_count <= line_count_next;
      name_line  <= name_line_next;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist[i] <= hist_next[i];
      end
    end
  end

  cmas_fifo #(
    .WIDTH($bits(cmas_pkg::res_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (item_pop && res_valid),
    .wr_data(res),
    .full   (out_full),
    .rd_en  (pop),
    .rd_data(res_out),
    .empty  (empty)
  );

endmodule

>>> rtl/comment_aware_macro_scanner.sv
`timescale 1ns / 1ps

// A byte is registered in the classified-byte queue, and its result is registered
// in the result queue that drives the result ports.
// Throughput: one byte per cycle while the result queue has room, set by the scan
// engine that reads the two-entry classified-byte queue.
// Reset (rst, synchronous): empties both queues and returns the scanner to plain
// code, line 1, with cleared history; no clearing pass is needed.
module comment_aware_macro_scanner #(
  parameter int KEYWORD_LENGTH = 17,
  parameter int LINE_BITS      = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  source_byte,
  input  logic        end_of_file,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  result_kind,
  output logic [7:0]  name_char,
  output logic [19:0] start_line
);

  cmas_pkg::item_t item;
  cmas_pkg::res_t  res_out;
  logic            item_empty;
  logic            item_pop;

  cmas_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .source_byte(source_byte),
    .end_of_file(end_of_file),
    .item_pop   (item_pop),
    .item       (item),
    .item_empty (item_empty)
  );

  cmas_back #(
    .KEYWORD_LENGTH(KEYWORD_LENGTH),
    .LINE_BITS     (LINE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .item_empty(item_empty),
    .item_pop  (item_pop),
    .pop       (pop),
    .res_out   (res_out),
    .empty     (empty)
  );

  assign result_kind = res_out.kind;
  assign name_char   = res_out.ch;
  assign start_line  = res_out.line;

endmodule
